>>> src/k_way_sorted_merge_macros.svh
// Assertion macros shared by the k-way merge RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef K_WAY_SORTED_MERGE_MACROS_SVH
`define K_WAY_SORTED_MERGE_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define KWM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An antecedent that requires a consequence in the next cycle.
`define KWM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/kwm_pkg.sv
// Shared types and constants of the k-way sorted merge block.
// No dependencies.
package kwm_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STATUS_PUSH_OK   = 2'd0,
    STATUS_PUSH_DROP = 2'd1,
    STATUS_POPPED    = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

endpackage

>>> src/kwm_store.sv
// Element store shared by all lists: one write port, one registered read port.
// Depends on kwm_pkg for the data width.
module kwm_store #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [ADDR_W-1:0]         wr_addr_i,
  input  logic [kwm_pkg::DATA_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [ADDR_W-1:0]         rd_addr_i,
  output logic [kwm_pkg::DATA_W-1:0] rd_data_o
);

  logic [kwm_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [kwm_pkg::DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/k_way_sorted_merge.sv
// K-way merge of sorted lists, served one element per pop request.
// Depends on kwm_pkg, kwm_store and k_way_sorted_merge_macros.svh.
//
// The block holds NUM_LISTS lists of up to LIST_DEPTH signed 32-bit values each, kept as
// ring buffers in one shared store. A push request appends to a list (or is dropped when
// the list is full or the list index is out of range); a pop request returns the smallest
// head over all lists, the lowest list index winning ties. One request is handled at a
// time. A push passes through the PUSH and DONE states into the output register, and a pop
// through SCAN, LAST, POP and DONE; SCAN is served by the single read port of the store
// and the one comparator, which visit the lists one per cycle. The next request is taken
// once the result has entered the output register. A finished result waits while the
// result ahead of it is still stalled at the output, and the input stays stalled meanwhile.
`include "k_way_sorted_merge_macros.svh"

module k_way_sorted_merge #(
  parameter int unsigned NUM_LISTS  = 8,
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [0:0]          req_type_i,
  input  logic [2:0]          list_id_i,
  input  logic signed [31:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  value_out_o
);

  localparam int unsigned ID_W   = $clog2(NUM_LISTS);
  localparam int unsigned SLOT_W = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SUM_W  = SLOT_W + 2;
  localparam int unsigned MEM_D  = NUM_LISTS * LIST_DEPTH;
  localparam int unsigned ADDR_W = $clog2(MEM_D);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PUSH = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_LAST = 6'b001000,
    ST_POP  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Per-list ring state.
  logic [SLOT_W-1:0] read_slot_q [NUM_LISTS];
  logic [CNT_W-1:0]  fill_q      [NUM_LISTS];

  // Request held while it is worked on.
  logic [2:0]                 id_q;
  logic [kwm_pkg::DATA_W-1:0] val_q;

  // Scan and compare stage.
  logic [ID_W-1:0]            scan_idx_q, scan_idx_d;
  logic                       cmp_act_q, cmp_act_d;
  logic                       cmp_ne_q, cmp_ne_d;
  logic [ID_W-1:0]            cmp_idx_q, cmp_idx_d;
  logic                       found_q, found_d;
  logic [ID_W-1:0]            best_idx_q, best_idx_d;
  logic signed [31:0]         best_val_q, best_val_d;

  // Pending result and output register.
  kwm_pkg::status_e           res_status_q, res_status_d;
  logic signed [31:0]         res_value_q, res_value_d;
  logic                       out_valid_q, out_valid_d;
  kwm_pkg::status_e           out_status_q;
  logic signed [31:0]         out_value_q;

  logic                       in_acc;
  logic                       out_load;
  logic [ID_W-1:0]            arr_idx;
  logic [SLOT_W-1:0]          slot_rd;
  logic [CNT_W-1:0]           fill_rd;
  logic                       id_oob;
  logic                       list_full;
  logic [SUM_W-1:0]           tail_sum;
  logic [SLOT_W-1:0]          tail_slot;
  logic [SLOT_W-1:0]          head_next;
  logic [ADDR_W-1:0]          list_base;
  logic                       arr_wr;
  logic [SLOT_W-1:0]          slot_wr;
  logic [CNT_W-1:0]           fill_wr;
  logic                       mem_wr;
  logic                       mem_rd;
  logic [kwm_pkg::DATA_W-1:0] mem_rdata;
  logic                       take;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // One index into the per-list arrays, chosen by what the sequencer is doing.
  always_comb begin
    unique case (state_q)
      ST_PUSH: arr_idx = ID_W'(id_q);
      ST_POP:  arr_idx = best_idx_q;
      default: arr_idx = scan_idx_q;
    endcase
  end

  assign slot_rd   = read_slot_q[arr_idx];
  assign fill_rd   = fill_q[arr_idx];
  assign id_oob    = 32'(id_q) >= NUM_LISTS;
  assign list_full = fill_rd == CNT_W'(LIST_DEPTH);

  // Tail slot: head plus fill, wrapped once since the sum stays below twice the depth.
  assign tail_sum  = SUM_W'(slot_rd) + SUM_W'(fill_rd);
  assign tail_slot = (tail_sum >= SUM_W'(LIST_DEPTH)) ?
                     SLOT_W'(tail_sum - SUM_W'(LIST_DEPTH)) : SLOT_W'(tail_sum);
  assign head_next = (slot_rd == SLOT_W'(LIST_DEPTH - 1)) ? '0 : slot_rd + 1'b1;
  assign list_base = ADDR_W'(ADDR_W'(arr_idx) * LIST_DEPTH);

  assign take = cmp_act_q && cmp_ne_q &&
                (!found_q || ($signed(mem_rdata) < best_val_q));

  always_comb begin
    state_d      = state_q;
    scan_idx_d   = scan_idx_q;
    cmp_act_d    = 1'b0;
    cmp_ne_d     = cmp_ne_q;
    cmp_idx_d    = cmp_idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_val_d   = best_val_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    arr_wr       = 1'b0;
    slot_wr      = slot_rd;
    fill_wr      = fill_rd;
    mem_wr       = 1'b0;
    mem_rd       = 1'b0;

    if (take) begin
      found_d    = 1'b1;
      best_idx_d = cmp_idx_q;
      best_val_d = $signed(mem_rdata);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          scan_idx_d = '0;
          found_d    = 1'b0;
          state_d    = (req_type_i == kwm_pkg::REQ_POP) ? ST_SCAN : ST_PUSH;
        end
      end
      ST_PUSH: begin
        res_value_d = '0;
        if (id_oob || list_full) begin
          res_status_d = kwm_pkg::STATUS_PUSH_DROP;
        end else begin
          res_status_d = kwm_pkg::STATUS_PUSH_OK;
          mem_wr       = 1'b1;
          arr_wr       = 1'b1;
          fill_wr      = fill_rd + 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        // Read the head of one list while the previous head is compared.
        mem_rd    = 1'b1;
        cmp_act_d = 1'b1;
        cmp_ne_d  = fill_rd != '0;
        cmp_idx_d = scan_idx_q;
        if (scan_idx_q == ID_W'(NUM_LISTS - 1)) begin
          state_d = ST_LAST;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      ST_LAST: begin
        state_d = ST_POP;
      end
      ST_POP: begin
        if (found_q) begin
          res_status_d = kwm_pkg::STATUS_POPPED;
          res_value_d  = best_val_q;
          arr_wr       = 1'b1;
          slot_wr      = head_next;
          fill_wr      = fill_rd - 1'b1;
        end else begin
          res_status_d = kwm_pkg::STATUS_EMPTY;
          res_value_d  = '0;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_idx_q  <= '0;
      cmp_act_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        read_slot_q[i] <= '0;
        fill_q[i]      <= '0;
      end
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      cmp_act_q   <= cmp_act_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (arr_wr) begin
        read_slot_q[arr_idx] <= slot_wr;
        fill_q[arr_idx]      <= fill_wr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      id_q  <= list_id_i;
      val_q <= value_i;
    end
    cmp_ne_q     <= cmp_ne_d;
    cmp_idx_q    <= cmp_idx_d;
    best_idx_q   <= best_idx_d;
    best_val_q   <= best_val_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
    end
  end

  kwm_store #(
    .DEPTH (MEM_D)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr),
    .wr_addr_i (list_base + ADDR_W'(tail_slot)),
    .wr_data_i (val_q),
    .rd_en_i   (mem_rd),
    .rd_addr_i (list_base + ADDR_W'(slot_rd)),
    .rd_data_o (mem_rdata)
  );

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_out_o = out_value_q;

  `KWM_ASSERT(a_value_zero_unless_popped,
              out_valid_o && (status_o != kwm_pkg::STATUS_POPPED) |-> value_out_o == '0,
              "value_out_o is not zero on a result without a popped value")
  `KWM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
                   "a new request was not followed by a busy cycle")
  `KWM_ASSERT(a_fill_bound, fill_rd <= CNT_W'(LIST_DEPTH),
              "a list holds more elements than its depth")
  `KWM_ASSERT(a_pop_nonempty, (state_q == ST_POP) && found_q |-> fill_rd != '0,
              "the chosen list is empty at pop time")

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for k_way_sorted_merge: directed and random push and pop requests.
// Results are checked against a behavioral merge model in this file or a row's fixed expectation.
// Depends on kwm_pkg and the k_way_sorted_merge RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LISTS  = 8;
  localparam int LIST_DEPTH = 64;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    kwm_pkg::status_e   status;
    logic signed [31:0] value;
  } merge_result_t;

  typedef struct {
    kwm_pkg::req_e      req;
    logic [2:0]         id;
    logic signed [31:0] val;
    int                 reps;
    bit                 typed;
    kwm_pkg::status_e   exp_status;
    logic signed [31:0] exp_value;
  } dir_row_t;

  typedef struct {
    int push_pct;
    int id_lo;
    int id_hi;
    bit idle_on;
    bit narrow;
  } phase_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [0:0]         req_type_i = 1'b0;
  logic [2:0]         list_id_i = 3'd0;
  logic signed [31:0] value_i = 32'sd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] value_out_o;

  // Model state of the merge: each list is a ring in its own row.
  logic signed [31:0] list_copy [NUM_LISTS][LIST_DEPTH];
  logic [5:0]         head_slot [NUM_LISTS];
  logic [6:0]         held      [NUM_LISTS];
  longint             last_pushed [NUM_LISTS];

  merge_result_t pending_results [$];
  int            error_count = 0;
  bit            long_hold_req = 1'b0;
  bit            quiet = 1'b0;

  dir_row_t directed_rows [15] = '{
    '{kwm_pkg::REQ_POP,  3'd0, 32'sd0,  1,  1'b1, kwm_pkg::STATUS_EMPTY,     32'sd0},
    '{kwm_pkg::REQ_PUSH, 3'd0, VAL_MIN, 1,  1'b1, kwm_pkg::STATUS_PUSH_OK,   32'sd0},
    '{kwm_pkg::REQ_PUSH, 3'd7, VAL_MAX, 1,  1'b1, kwm_pkg::STATUS_PUSH_OK,   32'sd0},
    '{kwm_pkg::REQ_PUSH, 3'd3, 32'sd0,  2,  1'b0, kwm_pkg::STATUS_PUSH_OK,   32'sd0},
    '{kwm_pkg::REQ_PUSH, 3'd5, 32'sd0,  1,  1'b0, kwm_pkg::STATUS_PUSH_OK,   32'sd0},
    '{kwm_pkg::REQ_PUSH, 3'd1, -32'sd1, 1,  1'b0, kwm_pkg::STATUS_PUSH_OK,   32'sd0},
    '{kwm_pkg::REQ_POP,  3'd6, 32'sd77, 5,  1'b0, kwm_pkg::STATUS_POPPED,    32'sd0},
    '{kwm_pkg::REQ_POP,  3'd2, -32'sd5, 1,  1'b0, kwm_pkg::STATUS_POPPED,    32'sd0},
    '{kwm_pkg::REQ_POP,  3'd0, 32'sd0,  1,  1'b1, kwm_pkg::STATUS_EMPTY,     32'sd0},
    '{kwm_pkg::REQ_PUSH, 3'd2, 32'sd5,  64, 1'b0, kwm_pkg::STATUS_PUSH_OK,   32'sd0},
    '{kwm_pkg::REQ_PUSH, 3'd2, 32'sd6,  1,  1'b1, kwm_pkg::STATUS_PUSH_DROP, 32'sd0},
    '{kwm_pkg::REQ_PUSH, 3'd2, -32'sd1, 1,  1'b1, kwm_pkg::STATUS_PUSH_DROP, 32'sd0},
    '{kwm_pkg::REQ_PUSH, 3'd6, 32'sh5555_5555, 1, 1'b0, kwm_pkg::STATUS_PUSH_OK, 32'sd0},
    '{kwm_pkg::REQ_PUSH, 3'd6, 32'shAAAA_AAAA, 1, 1'b0, kwm_pkg::STATUS_PUSH_OK, 32'sd0},
    '{kwm_pkg::REQ_POP,  3'd0, 32'sd0,  4,  1'b0, kwm_pkg::STATUS_POPPED,    32'sd0}
  };

  // Fill-heavy phases aimed at one or two lists drive them into the full case.
  phase_t phase_plan [8] = '{
    '{70, 0, 7, 1'b1, 1'b0},
    '{25, 0, 7, 1'b1, 1'b0},
    '{85, 0, 0, 1'b0, 1'b0},
    '{55, 0, 7, 1'b0, 1'b1},
    '{30, 0, 7, 1'b1, 1'b0},
    '{95, 4, 5, 1'b1, 1'b0},
    '{50, 0, 7, 1'b0, 1'b1},
    '{35, 0, 7, 1'b0, 1'b0}
  };

  k_way_sorted_merge #(
    .NUM_LISTS (NUM_LISTS),
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .list_id_i  (list_id_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .value_out_o(value_out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Applies one request to the model state and returns the result it produces.
  function automatic merge_result_t predict_merge(kwm_pkg::req_e req, logic [2:0] id,
                                                  logic signed [31:0] val);
    merge_result_t res;
    int best;
    logic signed [31:0] head_val;
    res.status = kwm_pkg::STATUS_PUSH_OK;
    res.value = 32'sd0;
    best = -1;
    if (req == kwm_pkg::REQ_PUSH) begin
      if (int'(id) >= NUM_LISTS || held[id] >= LIST_DEPTH) begin
        res.status = kwm_pkg::STATUS_PUSH_DROP;
      end else begin
        list_copy[id][6'(head_slot[id] + held[id])] = val;
        held[id] = held[id] + 7'd1;
      end
    end else begin
      for (int k = 0; k < NUM_LISTS; k++) begin
        if (held[k] != 7'd0) begin
          head_val = list_copy[k][head_slot[k]];
          // Strict compare keeps the lowest list index on equal heads.
          if (best < 0 || head_val < res.value) begin
            best = k;
            res.value = head_val;
          end
        end
      end
      if (best >= 0) begin
        head_slot[best] = head_slot[best] + 6'd1;
        held[best] = held[best] - 7'd1;
        res.status = kwm_pkg::STATUS_POPPED;
      end else begin
        res.status = kwm_pkg::STATUS_EMPTY;
      end
    end
    return res;
  endfunction

  // Next value for a list that keeps it ascending, at random restarting the base on an empty list.
  function automatic logic signed [31:0] next_sorted_value(int id, bit narrow);
    longint nxt;
    if (held[id] == 7'd0 && $urandom_range(0, 3) == 0) begin
      nxt = narrow ? longint'($urandom_range(0, 7)) : longint'($signed($urandom()));
    end else begin
      nxt = last_pushed[id] + (narrow ? $urandom_range(0, 1) : $urandom_range(0, 5000));
      if (nxt > 64'sd2147483647) begin
        nxt = 64'sd2147483647;
      end
    end
    last_pushed[id] = nxt;
    return nxt[31:0];
  endfunction

  // Starts at a falling edge and returns at the falling edge after acceptance.
  task automatic offer_request(kwm_pkg::req_e req, logic [2:0] id, logic signed [31:0] val,
                               bit typed, merge_result_t typed_res);
    merge_result_t predicted;
    in_valid_i <= 1'b1;
    req_type_i <= req;
    list_id_i <= id;
    value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_merge(req, id, val);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      pending_results.push_back(predicted);
    end
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  initial begin
    merge_result_t typed_res;
    phase_t ph;
    kwm_pkg::req_e req;
    logic [2:0] id;
    logic signed [31:0] val;
    for (int k = 0; k < NUM_LISTS; k++) begin
      head_slot[k] = 6'd0;
      held[k] = 7'd0;
      last_pushed[k] = longint'($signed($urandom())) >>> 2;
      for (int s = 0; s < LIST_DEPTH; s++) begin
        list_copy[k][s] = 32'sd0;
      end
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      typed_res.status = directed_rows[r].exp_status;
      typed_res.value = directed_rows[r].exp_value;
      repeat (directed_rows[r].reps) begin
        offer_request(directed_rows[r].req, directed_rows[r].id, directed_rows[r].val,
                      directed_rows[r].typed, typed_res);
      end
    end

    foreach (phase_plan[p]) begin
      ph = phase_plan[p];
      if (p == 2 || p == 6) begin
        // Let the block drain completely before going on.
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk_i);
      end
      if (p == 3) begin
        long_hold_req = 1'b1;
      end
      if (p == 7) begin
        quiet = 1'b1;
      end
      for (int i = 0; i < 100; i++) begin
        if (ph.idle_on && $urandom_range(0, 4) == 0) begin
          idle_sender($urandom_range(1, 19));
        end
        if ($urandom_range(1, 100) <= ph.push_pct) begin
          req = kwm_pkg::REQ_PUSH;
          id = 3'($urandom_range(ph.id_lo, ph.id_hi));
          val = ($urandom_range(0, 11) == 0) ? $signed($urandom())
                                             : next_sorted_value(id, ph.narrow);
        end else begin
          req = kwm_pkg::REQ_POP;
          id = 3'($urandom_range(0, 7));
          val = $signed($urandom());
        end
        offer_request(req, id, val, 1'b0, typed_res);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold that backs the block up, none at the end.
  initial begin
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    merge_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: status %0d value_out %0d",
               status_o, value_out_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          error_count++;
        end
        if (value_out_o !== want.value) begin
          $error("value_out: expected %0d, actual %0d", want.value, value_out_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
